/* src/wbfd_pkg.sv */
// ----------------------------------------------------------------------------
// wbfd_pkg
// Shared types and constants of the weather bit-frame decoder.
// ----------------------------------------------------------------------------
package wbfd_pkg;

    localparam int CHAR_W    = 8;
    localparam int TIME_W    = 32;
    localparam int FRAME_W   = 24;
    localparam int COUNT_W   = 6;
    localparam int TEMP_W    = 13;
    localparam int HUM_W     = 8;
    localparam int WINDOW_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [CHAR_W-1:0] CHAR_LF   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_ONE  = 8'd49;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUMIDITY_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_WINDOW = 3'd4;

    localparam logic [COUNT_W-1:0]  RST_MIN_LENGTH    = 6'd34;
    localparam logic [COUNT_W-1:0]  RST_MAX_LENGTH    = 6'd38;
    localparam logic [HUM_W-1:0]    RST_HUMIDITY_LOW  = 8'd20;
    localparam logic [HUM_W-1:0]    RST_HUMIDITY_HIGH = 8'd100;
    localparam logic [WINDOW_W-1:0] RST_REPEAT_WINDOW = 16'd1;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BAD_LENGTH = 3'd1,
        STATUS_BAD_CHAR   = 3'd2,
        STATUS_BAD_HUM    = 3'd3,
        STATUS_REPEAT     = 3'd4
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  min_length;
        logic [COUNT_W-1:0]  max_length;
        logic [HUM_W-1:0]    humidity_low;
        logic [HUM_W-1:0]    humidity_high;
        logic [WINDOW_W-1:0] repeat_window;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [COUNT_W-1:0] count;
        logic               bad_char;
    } line_t;

    typedef struct packed {
        logic [HUM_W-1:0]         humidity;
        logic signed [TEMP_W-1:0] temperature_tenths;
        status_t                  status;
    } result_t;

endpackage

/* src/wbfd_line.sv */
// ----------------------------------------------------------------------------
// wbfd_line
// Line assembly: holds each character one transfer, then shifts bits into
// the frame and counts them; a line feed drops the held character and clears.
// ----------------------------------------------------------------------------
module wbfd_line
    import wbfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [CHAR_W-1:0] character,
    output line_t             line
);

    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               bad_reg, bad_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [CHAR_W-1:0]  pend_char_reg, pend_char_next;

    always_comb begin
        frame_next      = frame_reg;
        count_next      = count_reg;
        bad_next        = bad_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        if (step) begin
            if (character == CHAR_LF) begin
                frame_next      = '0;
                count_next      = '0;
                bad_next        = 1'b0;
                pend_valid_next = 1'b0;
                pend_char_next  = '0;
            end else begin
                if (pend_valid_reg) begin
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (pend_char_reg == CHAR_ONE) begin
                        frame_next = {frame_reg[FRAME_W-2:0], 1'b1};
                    end else if (pend_char_reg == CHAR_ZERO) begin
                        frame_next = {frame_reg[FRAME_W-2:0], 1'b0};
                    end else begin
                        bad_next = 1'b1;
                    end
                end
                pend_valid_next = 1'b1;
                pend_char_next  = character;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_reg      <= '0;
            count_reg      <= '0;
            bad_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_char_reg  <= '0;
        end else begin
            frame_reg      <= frame_next;
            count_reg      <= count_next;
            bad_reg        <= bad_next;
            pend_valid_reg <= pend_valid_next;
            pend_char_reg  <= pend_char_next;
        end
    end

    assign line = '{frame: frame_reg, count: count_reg, bad_char: bad_reg};

endmodule

/* src/wbfd_eval.sv */
// ----------------------------------------------------------------------------
// wbfd_eval
// Line evaluation: length, character, humidity and repeat checks on a
// finished line, and the store of the last accepted reading.
// ----------------------------------------------------------------------------
module wbfd_eval
    import wbfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              update,
    input  line_t             line,
    input  logic [TIME_W-1:0] now_seconds,
    input  cfg_t              cfg,
    output result_t           result
);

    logic [TEMP_W-1:0] last_temp_reg;
    logic [HUM_W-1:0]  last_hum_reg;
    logic [TIME_W-1:0] last_time_reg;

    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;
    logic [TIME_W-1:0] elapsed;
    logic              bad_length;
    logic              bad_hum;
    logic              repeat_hit;
    status_t           status;

    always_comb begin
        hum        = line.frame[7:0];
        temp       = {(line.frame[23:20] == 4'hF), line.frame[23:12]};
        elapsed    = now_seconds - last_time_reg;
        bad_length = (line.count < cfg.min_length) || (line.count > cfg.max_length);
        bad_hum    = (hum < cfg.humidity_low) || (hum > cfg.humidity_high);
        repeat_hit = (elapsed <= TIME_W'(cfg.repeat_window))
                     && (last_temp_reg == temp) && (last_hum_reg == hum);
        priority if (bad_length) begin
            status = STATUS_BAD_LENGTH;
        end else if (line.bad_char) begin
            status = STATUS_BAD_CHAR;
        end else if (bad_hum) begin
            status = STATUS_BAD_HUM;
        end else if (repeat_hit) begin
            status = STATUS_REPEAT;
        end else begin
            status = STATUS_OK;
        end
        result.status = status;
        if (bad_length || line.bad_char) begin
            result.temperature_tenths = '0;
            result.humidity           = '0;
        end else begin
            result.temperature_tenths = temp;
            result.humidity           = hum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
            last_time_reg <= '0;
        end else if (update && status == STATUS_OK) begin
            last_temp_reg <= temp;
            last_hum_reg  <= hum;
            last_time_reg <= now_seconds;
        end
    end

endmodule

/* src/weather_bit_frame_decoder_core.sv */
// ----------------------------------------------------------------------------
// weather_bit_frame_decoder_core
// Decodes lines of '0'/'1' characters from a weather sensor into status,
// temperature and humidity results.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel carries one character per transfer with the current time
// in seconds. Every character except a line feed only updates the line state;
// the character right before a line feed is dropped. A line feed produces one
// result transfer on the master channel: status, temperature in tenths of a
// degree and humidity.
// A character is registered on transfer and evaluated from the input register;
// a line feed's result is registered in the output register for the master channel.
// Throughput: one character per cycle. The input register frees itself in
// every cycle except when it holds a line feed while an earlier result is
// still stalled by the receiver; then s_tready drops until m_tready returns.
// Thresholds are written through the cfg_ port while the stream is idle.
// Reset (aresetn low, synchronous) restores the default thresholds, empties
// the line, clears the last-reading store and drops both valid flags.
// ----------------------------------------------------------------------------
module weather_bit_frame_decoder_core
    import wbfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // character [7:0], now_seconds [39:8]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status [2:0], temperature_tenths [15:3],
                                             // humidity [23:16]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic    in_is_lf;
    logic    advance;
    line_t   line;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_length    <= RST_MIN_LENGTH;
            cfg_reg.max_length    <= RST_MAX_LENGTH;
            cfg_reg.humidity_low  <= RST_HUMIDITY_LOW;
            cfg_reg.humidity_high <= RST_HUMIDITY_HIGH;
            cfg_reg.repeat_window <= RST_REPEAT_WINDOW;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_LENGTH:    cfg_reg.min_length    <= cfg_wdata[COUNT_W-1:0];
                REG_MAX_LENGTH:    cfg_reg.max_length    <= cfg_wdata[COUNT_W-1:0];
                REG_HUMIDITY_LOW:  cfg_reg.humidity_low  <= cfg_wdata[HUM_W-1:0];
                REG_HUMIDITY_HIGH: cfg_reg.humidity_high <= cfg_wdata[HUM_W-1:0];
                REG_REPEAT_WINDOW: cfg_reg.repeat_window <= cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_is_lf = (in_char_reg == CHAR_LF);
    assign advance  = in_valid_reg && (!in_is_lf || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_time_reg <= s_tdata[CHAR_W+TIME_W-1:CHAR_W];
        end
    end

    wbfd_line u_line (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .character (in_char_reg),
        .line      (line)
    );

    wbfd_eval u_eval (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .update      (advance && in_is_lf),
        .line        (line),
        .now_seconds (in_time_reg),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_is_lf) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_is_lf) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

/* src/wbfd_checker.sv */
// ----------------------------------------------------------------------------
// wbfd_checker
// Port-level checks of the weather bit-frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module wbfd_checker
    import wbfd_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == STATUS_OK || m_tdata[2:0] == STATUS_BAD_LENGTH
                      || m_tdata[2:0] == STATUS_BAD_CHAR || m_tdata[2:0] == STATUS_BAD_HUM
                      || m_tdata[2:0] == STATUS_REPEAT))
        else $error("Undefined status code.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == STATUS_BAD_LENGTH || m_tdata[2:0] == STATUS_BAD_CHAR)
        |-> m_tdata[23:3] == '0)
        else $error("Rejected line carries nonzero reading.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result transfer changed.");

endmodule

bind weather_bit_frame_decoder_core wbfd_checker u_wbfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/weather_bit_frame_decoder_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weather_bit_frame_decoder_core_test
// Self-checking bench for the weather bit-frame decoder. A short table of
// sensor lines covers empty, long, malformed and boundary lines and register
// extremes. It is followed by random lines, most of them well formed, under
// several threshold settings and three patterns of stream back-pressure.
// Every result transfer is compared with the expected result of a table row
// that gives one, else with a software decoder fed the accepted characters.
// ----------------------------------------------------------------------------
module weather_bit_frame_decoder_core_test;
    import wbfd_pkg::*;

    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
    localparam int SETTLE_CYCLES = 6;
    localparam int SEG_CHARS = 210;
    localparam int CYCLE_LIMIT = 600000;
    localparam result_t NO_RESULT = '{8'd0, 13'd0, STATUS_OK};

    // For a register write, nbits holds the register index and bits the value.
    typedef struct {
        bit          is_write;
        int          nbits;
        logic [63:0] bits;
        int          bad_at;
        logic [7:0]  odd;
        int          tail;
        logic [31:0] stamp;
        bit          typed;
        result_t     want;
    } line_row_t;

    line_row_t plan [25] = '{
        '{1'b0, 0, 64'h0, -1, 8'h00, -1, 32'd5, 1'b1, '{8'd0, 13'd0, STATUS_BAD_LENGTH}},
        '{1'b0, 70, 64'hFFFF_FFFF_FFFF_FFFF, -1, 8'h00, 13, 32'd6, 1'b1,
          '{8'd0, 13'd0, STATUS_BAD_LENGTH}},
        '{1'b0, 36, 64'h0, 5, 8'hFF, 13, 32'd7, 1'b1, '{8'd0, 13'd0, STATUS_BAD_CHAR}},
        '{1'b0, 36, 64'h5_5555_5555, 0, 8'h00, 13, 32'd8, 1'b1,
          '{8'd0, 13'd0, STATUS_BAD_CHAR}},
        '{1'b0, 33, 64'h1_2345_6789, -1, 8'h00, 13, 32'd9, 1'b1,
          '{8'd0, 13'd0, STATUS_BAD_LENGTH}},
        '{1'b0, 39, 64'h12_3456_7890, -1, 8'h00, 13, 32'd10, 1'b1,
          '{8'd0, 13'd0, STATUS_BAD_LENGTH}},
        '{1'b0, 36, 64'hF_FFFF_FFFF, -1, 8'h00, 13, 32'd11, 1'b1,
          '{8'hFF, 13'h1FFF, STATUS_BAD_HUM}},
        '{1'b1, REG_HUMIDITY_LOW, 64'd0, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b0, 34, 64'h0, -1, 8'h00, 13, 32'd1, 1'b1, '{8'd0, 13'd0, STATUS_REPEAT}},
        '{1'b0, 34, 64'h0, -1, 8'h00, 13, 32'hFFFF_FFFF, 1'b1, '{8'd0, 13'd0, STATUS_OK}},
        '{1'b0, 34, 64'h0, -1, 8'h00, 13, 32'd0, 1'b1, '{8'd0, 13'd0, STATUS_REPEAT}},
        '{1'b1, REG_MIN_LENGTH, 64'd0, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b1, REG_MAX_LENGTH, 64'd63, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b1, REG_HUMIDITY_HIGH, 64'd255, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b1, REG_REPEAT_WINDOW, 64'd65535, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b0, 36, 64'h12_3432, -1, 8'h00, 255, 32'd100, 1'b0, NO_RESULT},
        '{1'b0, 36, 64'h12_3432, -1, 8'h00, 13, 32'd65635, 1'b0, NO_RESULT},
        '{1'b0, 36, 64'h12_3432, -1, 8'h00, 13, 32'd65636, 1'b0, NO_RESULT},
        '{1'b0, 37, 64'h1F3_80A1, -1, 8'h00, -1, 32'd70000, 1'b0, NO_RESULT},
        '{1'b0, 24, 64'hE0_0040, -1, 8'h00, 13, 32'd200, 1'b0, NO_RESULT},
        '{1'b0, 0, 64'h0, -1, 8'h00, -1, 32'd300, 1'b0, NO_RESULT},
        '{1'b1, REG_REPEAT_WINDOW, 64'd0, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b1, REG_MIN_LENGTH, 64'd63, -1, 8'h00, -1, 32'd0, 1'b0, NO_RESULT},
        '{1'b0, 80, 64'hDEAD_BEEF_0123_4567, -1, 8'h00, 13, 32'd300, 1'b0, NO_RESULT},
        '{1'b0, 80, 64'hDEAD_BEEF_0123_4567, -1, 8'h00, 13, 32'd300, 1'b0, NO_RESULT}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int chars_sent = 0;
    result_t readings_due [$];

    cfg_t               thresholds = '{RST_MIN_LENGTH, RST_MAX_LENGTH, RST_HUMIDITY_LOW,
                                       RST_HUMIDITY_HIGH, RST_REPEAT_WINDOW};
    logic [FRAME_W-1:0] line_frame = '0;
    logic [COUNT_W-1:0] line_count = '0;
    logic               line_bad = 1'b0;
    logic               held_valid = 1'b0;
    logic [CHAR_W-1:0]  held_char = '0;
    logic [TEMP_W-1:0]  store_temp = '0;
    logic [HUM_W-1:0]   store_hum = '0;
    logic [TIME_W-1:0]  store_time = '0;

    weather_bit_frame_decoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit decode_char(input logic [CHAR_W-1:0] ch,
                                       input logic [TIME_W-1:0] now,
                                       output result_t r);
        logic [TIME_W-1:0] age;
        r = NO_RESULT;
        if (ch != CHAR_LF) begin
            if (held_valid) begin
                if (line_count != COUNT_MAX) begin
                    line_count = line_count + COUNT_W'(1);
                end
                if (held_char == CHAR_ONE) begin
                    line_frame = {line_frame[FRAME_W-2:0], 1'b1};
                end else if (held_char == CHAR_ZERO) begin
                    line_frame = {line_frame[FRAME_W-2:0], 1'b0};
                end else begin
                    line_bad = 1'b1;
                end
            end
            held_char = ch;
            held_valid = 1'b1;
            return 1'b0;
        end
        if (line_count < thresholds.min_length || line_count > thresholds.max_length) begin
            r.status = STATUS_BAD_LENGTH;
        end else if (line_bad) begin
            r.status = STATUS_BAD_CHAR;
        end else begin
            r.humidity = line_frame[7:0];
            r.temperature_tenths = {&line_frame[23:20], line_frame[23:12]};
            age = now - store_time;
            if (r.humidity < thresholds.humidity_low
                    || r.humidity > thresholds.humidity_high) begin
                r.status = STATUS_BAD_HUM;
            end else if (age <= {16'd0, thresholds.repeat_window}
                    && store_temp == r.temperature_tenths && store_hum == r.humidity) begin
                r.status = STATUS_REPEAT;
            end else begin
                r.status = STATUS_OK;
                store_temp = r.temperature_tenths;
                store_hum = r.humidity;
                store_time = now;
            end
        end
        line_frame = '0;
        line_count = '0;
        line_bad = 1'b0;
        held_valid = 1'b0;
        held_char = '0;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic [TIME_W-1:0] now,
                             input bit typed, input result_t want);
        result_t r;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {now, ch};
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
        if (decode_char(ch, now, r)) begin
            readings_due.push_back(typed ? want : r);
        end
    endtask

    task automatic send_line(input int nbits, input logic [63:0] bits, input int bad_at,
                             input logic [7:0] odd, input int tail,
                             input logic [TIME_W-1:0] now, input bit typed,
                             input result_t want);
        int j;
        logic [CHAR_W-1:0] ch;
        for (int i = 0; i < nbits; i++) begin
            j = nbits - 1 - i;
            if (i == bad_at) begin
                ch = odd;
            end else if (j < 64 && bits[j]) begin
                ch = CHAR_ONE;
            end else begin
                ch = CHAR_ZERO;
            end
            send_char(ch, $urandom(), 1'b0, NO_RESULT);
        end
        if (tail >= 0) begin
            send_char(8'(tail), $urandom(), 1'b0, NO_RESULT);
        end
        send_char(CHAR_LF, now, typed, want);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (index)
            REG_MIN_LENGTH:    thresholds.min_length = value[COUNT_W-1:0];
            REG_MAX_LENGTH:    thresholds.max_length = value[COUNT_W-1:0];
            REG_HUMIDITY_LOW:  thresholds.humidity_low = value[HUM_W-1:0];
            REG_HUMIDITY_HIGH: thresholds.humidity_high = value[HUM_W-1:0];
            REG_REPEAT_WINDOW: thresholds.repeat_window = value[WINDOW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= dst_idle_pct);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("weather_bit_frame_decoder_core_test: FAIL");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata);
            if (readings_due.size() == 0) begin
                report_mismatch("result transfer with nothing due", 32'(m_tdata), 32'd0);
            end else begin
                want = readings_due.pop_front();
                if (got.status != want.status) begin
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                end
                if (got.temperature_tenths != want.temperature_tenths) begin
                    report_mismatch("temperature", 32'(unsigned'(got.temperature_tenths)),
                                    32'(unsigned'(want.temperature_tenths)));
                end
                if (got.humidity != want.humidity) begin
                    report_mismatch("humidity", 32'(got.humidity), 32'(want.humidity));
                end
            end
        end
    end

    initial begin
        int seg, kind, nbits, bad_at, tail, lo, hi, stop, prev_nbits, roll;
        logic [63:0] bits, prev_bits;
        logic [TIME_W-1:0] wall;
        logic [7:0] odd, hum_lo;
        logic [WINDOW_W-1:0] window;
        prev_bits = '0;
        prev_nbits = 0;
        wall = 32'd1000;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 17;
        dst_idle_pct = 86;
        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                write_reg(CFG_IDX_W'(plan[i].nbits), CFG_DATA_W'(plan[i].bits));
            end else begin
                send_line(plan[i].nbits, plan[i].bits, plan[i].bad_at, plan[i].odd,
                          plan[i].tail, plan[i].stamp, plan[i].typed, plan[i].want);
            end
        end

        for (seg = 0; seg < 6; seg++) begin
            src_idle_pct = (seg < 2) ? 17 : (seg < 4) ? 86 : 0;
            dst_idle_pct = (seg < 2) ? 86 : (seg < 4) ? 17 : 0;
            lo = $urandom_range(51, 0);
            hi = lo + $urandom_range(12, 0);
            if ($urandom_range(9, 0) == 0) begin
                write_reg(REG_MIN_LENGTH, CFG_DATA_W'(hi));
                write_reg(REG_MAX_LENGTH, CFG_DATA_W'(lo));
            end else begin
                write_reg(REG_MIN_LENGTH, CFG_DATA_W'(lo));
                write_reg(REG_MAX_LENGTH, CFG_DATA_W'(hi));
            end
            hum_lo = 8'($urandom_range(60, 0));
            write_reg(REG_HUMIDITY_LOW, CFG_DATA_W'(hum_lo));
            write_reg(REG_HUMIDITY_HIGH, CFG_DATA_W'(int'(hum_lo) + $urandom_range(195, 0)));
            case ($urandom_range(3, 0))
                0: window = '0;
                1: window = 16'($urandom_range(3, 0));
                2: window = 16'($urandom());
                default: window = '1;
            endcase
            write_reg(REG_REPEAT_WINDOW, window);

            stop = chars_sent + SEG_CHARS;
            while (chars_sent < stop) begin
                kind = $urandom_range(99, 0);
                lo = int'(thresholds.min_length);
                hi = int'(thresholds.max_length);
                nbits = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(63, 0);
                bits = {$urandom(), $urandom()};
                if ($urandom_range(3, 0) == 0) begin
                    bits[23:20] = 4'hF;
                end
                if (thresholds.humidity_low <= thresholds.humidity_high
                        && $urandom_range(4, 0) != 0) begin
                    bits[7:0] = 8'($urandom_range(thresholds.humidity_high,
                                                  thresholds.humidity_low));
                end
                if ($urandom_range(99, 0) < 35) begin
                    bits = prev_bits;
                    nbits = prev_nbits;
                end
                bad_at = -1;
                odd = 8'($urandom_range(255, 0));
                roll = $urandom_range(99, 0);
                if (roll >= 90) begin
                    tail = -1;
                end else if (roll >= 78) begin
                    tail = $urandom_range(255, 0);
                end else begin
                    tail = int'(CHAR_CR);
                end
                if (kind < 12) begin
                    nbits = $urandom_range(72, 0);
                end else if (kind < 26) begin
                    if (nbits > 0) begin
                        bad_at = $urandom_range(nbits - 1, 0);
                    end
                end else if (kind < 34) begin
                    repeat ($urandom_range(12, 0)) begin
                        send_char(8'($urandom_range(255, 0)), $urandom(), 1'b0, NO_RESULT);
                    end
                    nbits = 0;
                    tail = -1;
                end
                roll = $urandom_range(99, 0);
                if (roll < 6) begin
                    wall = $urandom();
                end else if (roll < 25) begin
                    wall = wall + 32'(thresholds.repeat_window) + 32'($urandom_range(1, 0));
                end else begin
                    wall = wall + 32'($urandom_range(2, 0));
                end
                send_line(nbits, bits, bad_at, odd, tail, wall, 1'b0, NO_RESULT);
                prev_bits = bits;
                prev_nbits = nbits;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("weather_bit_frame_decoder_core_test: PASS");
        end else begin
            $display("weather_bit_frame_decoder_core_test: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/wbfd_pkg.sv
src/wbfd_line.sv
src/wbfd_eval.sv
src/weather_bit_frame_decoder_core.sv
src/wbfd_checker.sv
test/weather_bit_frame_decoder_core_test.sv
